@@ sv/tccw_pkg.sv @@
package tccw_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OpPut   = 2'd0;
  localparam logic [1:0] OpClear = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // Character codes with special handling
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharBlank     = 8'h20;

  // Attribute after reset
  localparam logic [7:0] ResetAttr = 8'h07;

  // Register word index on the configuration port
  localparam logic RegTextAttr = 1'b0;

  // Fixed field widths
  localparam int InAddrW = 11;
  localparam int PosW    = 11;
  localparam int RowOutW = 5;
  localparam int ColOutW = 7;
  localparam int CellW   = 16;

  // Controller states
  typedef enum logic [5:0] {
    StInit = 6'b000001,
    StIdle = 6'b000010,
    StRead = 6'b000100,
    StCopy = 6'b001000,
    StFill = 6'b010000,
    StDone = 6'b100000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_capture;
    logic copy;
    logic fill;
    logic fill_reset;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_read;
    logic start_clear;
    logic start_scroll;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/tccw_chan_if.sv @@
// Input item channel
interface tccw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [10:0] cell_address;

  modport source (output valid, output opcode, output char_code, output cell_address,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input cell_address,
                output ready);
endinterface

// Result item channel
interface tccw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_col_out;
  logic [15:0] cell_data;
  logic        scrolled;

  modport source (output valid, output cursor_position, output cursor_row_out,
                  output cursor_col_out, output cell_data, output scrolled,
                  input ready);
  modport sink (input valid, input cursor_position, input cursor_row_out,
                input cursor_col_out, input cell_data, input scrolled,
                output ready);
endinterface

@@ sv/tccw_ctrl.sv @@
module tccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tccw_pkg::status_t st_i,
  output tccw_pkg::cmd_t    cmd_o
);

  tccw_pkg::state_e state_q, state_d;

  // Sequence one item: start, sweep or read, then hand over the result
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tccw_pkg::StInit: begin
        cmd_o.fill       = 1'b1;
        cmd_o.fill_reset = 1'b1;
        if (st_i.fill_last) state_d = tccw_pkg::StIdle;
      end
      tccw_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (st_i.start_read)   state_d = tccw_pkg::StRead;
          else if (st_i.start_clear)      state_d = tccw_pkg::StFill;
          else if (st_i.start_scroll)     state_d = tccw_pkg::StCopy;
          else                            state_d = tccw_pkg::StDone;
        end
      end
      tccw_pkg::StRead: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = tccw_pkg::StDone;
      end
      tccw_pkg::StCopy: begin
        cmd_o.copy = 1'b1;
        if (st_i.copy_last) state_d = tccw_pkg::StFill;
      end
      tccw_pkg::StFill: begin
        cmd_o.fill = 1'b1;
        if (st_i.fill_last) state_d = tccw_pkg::StDone;
      end
      tccw_pkg::StDone: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = tccw_pkg::StIdle;
        end
      end
      default: state_d = tccw_pkg::StIdle;
    endcase
  end

  // Hold state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::StInit;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/tccw_dp.sv @@
module tccw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tccw_pkg::cmd_t                 cmd_i,
  output tccw_pkg::status_t              st_o,
  input  logic [7:0]                     attr_i,
  input  logic [1:0]                     opcode_i,
  input  logic [7:0]                     char_code_i,
  input  logic [tccw_pkg::InAddrW-1:0]   cell_address_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [tccw_pkg::PosW-1:0]      cursor_position_o,
  output logic [tccw_pkg::RowOutW-1:0]   cursor_row_out_o,
  output logic [tccw_pkg::ColOutW-1:0]   cursor_col_out_o,
  output logic [tccw_pkg::CellW-1:0]     cell_data_o,
  output logic                           scrolled_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int LW    = $clog2(COLUMNS);
  localparam int AW    = (CW > tccw_pkg::InAddrW) ? CW : tccw_pkg::InAddrW;

  logic [tccw_pkg::CellW-1:0] mem [CELLS];

  logic [RW-1:0] row_q, row_d;
  logic [LW-1:0] col_q, col_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic          rd_ok_q;
  logic          scr_q, scr_d;
  logic [tccw_pkg::CellW-1:0] rdata_q;
  logic [tccw_pkg::CellW-1:0] cdata_q, cdata_d;

  logic [CW-1:0] cur_idx;
  logic [AW-1:0] addr_ext;
  logic [CW:0]   copy_src;
  logic          copy_rd_ok;
  logic          is_put, is_nl, is_cr, is_bs, printable;
  logic          col_last, row_last, col_zero, adv_row;

  logic                       mem_we, mem_re;
  logic [CW-1:0]              mem_wa, mem_ra;
  logic [tccw_pkg::CellW-1:0] mem_wd;

  // Decode the item and the cursor
  assign cur_idx   = CW'(row_q * COLUMNS) + CW'(col_q);
  assign addr_ext  = AW'(cell_address_i);
  assign is_put    = (opcode_i == tccw_pkg::OpPut);
  assign is_nl     = (char_code_i == tccw_pkg::CharNewline);
  assign is_cr     = (char_code_i == tccw_pkg::CharReturn);
  assign is_bs     = (char_code_i == tccw_pkg::CharBackspace);
  assign printable = is_put && !is_nl && !is_cr && !is_bs;
  assign col_last  = (col_q == LW'(COLUMNS - 1));
  assign row_last  = (row_q == RW'(ROWS - 1));
  assign col_zero  = (col_q == '0);
  assign adv_row   = is_put && (is_nl || (printable && col_last));

  // Copy reads run one cell ahead of the writes
  assign copy_src   = {1'b0, cnt_q} + (CW + 1)'(pend_q) + (CW + 1)'(COLUMNS);
  assign copy_rd_ok = (copy_src < (CW + 1)'(CELLS));

  // Report status
  always_comb begin
    st_o.start_read   = (opcode_i == tccw_pkg::OpRead);
    st_o.start_clear  = (opcode_i == tccw_pkg::OpClear);
    st_o.start_scroll = adv_row && row_last;
    st_o.copy_last    = pend_q && (cnt_q == CW'(CELLS - COLUMNS - 1));
    st_o.fill_last    = (cnt_q == CW'(CELLS - 1));
    st_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Update cursor on a new item
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.accept) begin
      if (is_put) begin
        if (is_nl || is_cr) begin
          col_d = '0;
        end else if (is_bs) begin
          if (!col_zero) col_d = col_q - LW'(1);
        end else if (col_last) begin
          col_d = '0;
        end else begin
          col_d = col_q + LW'(1);
        end
        if (adv_row && !row_last) row_d = row_q + RW'(1);
      end else if (opcode_i == tccw_pkg::OpClear) begin
        row_d = '0;
        col_d = '0;
      end
    end
  end

  // Select the memory write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q;
    mem_wd = {attr_i, tccw_pkg::CharBlank};
    priority if (cmd_i.fill) begin
      mem_we = 1'b1;
      if (cmd_i.fill_reset) mem_wd = {tccw_pkg::ResetAttr, tccw_pkg::CharBlank};
    end else if (cmd_i.copy) begin
      mem_we = pend_q;
      mem_wd = rdata_q;
    end else if (cmd_i.accept && printable) begin
      mem_we = 1'b1;
      mem_wa = cur_idx;
      mem_wd = {attr_i, char_code_i};
    end else if (cmd_i.accept && is_put && is_bs && !col_zero) begin
      mem_we = 1'b1;
      mem_wa = cur_idx - CW'(1);
    end else begin
      mem_we = 1'b0;
    end
  end

  // Select the memory read
  assign mem_re = (cmd_i.accept && st_o.start_read) || (cmd_i.copy && copy_rd_ok);
  assign mem_ra = cmd_i.copy ? copy_src[CW-1:0] : addr_ext[CW-1:0];

  // Screen store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  // Advance the sweep counter
  always_comb begin
    cnt_d  = cnt_q;
    pend_d = 1'b0;
    if (cmd_i.accept) begin
      cnt_d = '0;
    end else if (cmd_i.fill) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.copy) begin
      pend_d = copy_rd_ok;
      if (pend_q) cnt_d = cnt_q + CW'(1);
    end
  end

  // Build the result fields
  always_comb begin
    cdata_d = cdata_q;
    scr_d   = scr_q;
    if (cmd_i.accept) begin
      cdata_d = '0;
      scr_d   = st_o.start_scroll;
    end else if (cmd_i.rd_capture) begin
      cdata_d = rd_ok_q ? rdata_q : '0;
    end
  end

  // Hold output valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cdata_q <= cdata_d;
    scr_q   <= scr_d;
    if (cmd_i.accept) rd_ok_q <= (addr_ext < AW'(CELLS));
    if (cmd_i.load_out) begin
      cursor_position_o <= tccw_pkg::PosW'(cur_idx);
      cursor_row_out_o  <= tccw_pkg::RowOutW'(row_q);
      cursor_col_out_o  <= tccw_pkg::ColOutW'(col_q);
      cell_data_o       <= cdata_q;
      scrolled_o        <= scr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/text_console_cell_writer.sv @@
// Character-cell terminal engine with a COLUMNS x ROWS screen store of 16-bit
// cells (attribute high byte, character low byte) and a cursor.
// Channels: in_i carries opcode, char_code and cell_address; res_o returns one
// result item per input item with the cursor after the operation, the cell
// read (read operation only) and a scroll flag. Both use valid/ready.
// The APB port holds the text attribute at byte address 0; pready is tied high.
// Steps from accept to result valid, with the screen store in one memory of
// one write and one read port:
//   put character without scroll, unused opcode: result loaded directly
//   read one cell: registered memory read, then the cell is captured
//   clear screen: every cell blanked, one cell written per cycle
//   scroll: copy of ROWS-1 rows, then the bottom row is blanked
// One item is worked at a time; the next item is taken as soon as the
// previous result sits in the output register.
// After reset every cell of the store is blanked to 0x0720 while no item is
// accepted; configuration writes are taken.
// A stalled receiver holds the result register, and a finished item then
// waits until that register is free.
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tccw_in_if.sink      in_i,
  tccw_out_if.source   res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t st;
  logic [7:0]        attr_q;
  logic              cfg_wr;

  // Register port: text attribute
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tccw_pkg::RegTextAttr);
  assign prdata = (paddr[2] == tccw_pkg::RegTextAttr) ? {24'd0, attr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccw_pkg::ResetAttr;
    end else if (cfg_wr) begin
      attr_q <= pwdata[7:0];
    end
  end

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .attr_i            (attr_q),
    .opcode_i          (in_i.opcode),
    .char_code_i       (in_i.char_code),
    .cell_address_i    (in_i.cell_address),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .cursor_position_o (res_o.cursor_position),
    .cursor_row_out_o  (res_o.cursor_row_out),
    .cursor_col_out_o  (res_o.cursor_col_out),
    .cell_data_o       (res_o.cell_data),
    .scrolled_o        (res_o.scrolled)
  );

  // No sweep may run while items are taken
  a_no_sweep_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !(cmd.copy || cmd.fill))
    else $error("memory sweep active while accepting items");

  // A read item captures its cell in the next cycle
  a_read_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && st.start_read) |=> cmd.rd_capture)
    else $error("read data not captured after read item");

  // The row copy is always followed by blanking the bottom row
  a_copy_then_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.copy && st.copy_last) |=> (cmd.fill && !cmd.fill_reset))
    else $error("scroll copy not followed by bottom row fill");

  // Loading the result makes it visible
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> res_o.valid)
    else $error("loaded result not presented");

endmodule
